// File: design/fbfd_pkg.sv
// ----------------------------------------------------------------------------
// fbfd_pkg
// Shared sizes, reset values, register codes and control types of the
// flash beacon frequency detector.
// ----------------------------------------------------------------------------
package fbfd_pkg;

    localparam int PERIOD_DEPTH = 10;
    localparam int WINDOW_DEPTH = 10;

    localparam int SAMPLE_W   = 10;
    localparam int TIME_W     = 32;
    localparam int PERIOD_W   = 16;
    localparam int FREQ_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int PIDX_W = (PERIOD_DEPTH > 1) ? $clog2(PERIOD_DEPTH) : 1;
    localparam int WIDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SCAN_N = (PERIOD_DEPTH > WINDOW_DEPTH) ? PERIOD_DEPTH : WINDOW_DEPTH;
    localparam int SCAN_W = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;
    localparam int CNT_W  = $clog2(PERIOD_DEPTH + 1);
    localparam int SUM_W  = PERIOD_W + CNT_W;
    localparam int DIV_W  = SUM_W;
    localparam int DCNT_W = $clog2(DIV_W + 1);

    localparam logic [SAMPLE_W-1:0]   SENS_RST   = 10'd30;
    localparam logic [PERIOD_W-1:0]   PLOW_RST   = 16'd40;
    localparam logic [PERIOD_W-1:0]   PHIGH_RST  = 16'd600;
    localparam logic [PERIOD_W-1:0]   SIL_RST    = 16'd600;
    localparam logic [SAMPLE_W-1:0]   WINDOW_RST = 10'd512;
    localparam logic [SAMPLE_W-1:0]   SAMPLE_MAX = 10'd1023;
    localparam logic [FREQ_W-1:0]     FREQ_MAX   = 5'd31;
    localparam int                    FREQ_NUM   = 1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENSITIVITY = 2'd0,
        CFG_PERIOD_LOW  = 2'd1,
        CFG_PERIOD_HIGH = 2'd2,
        CFG_SILENCE     = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PULSE,
        ST_SCAN,
        ST_COMMIT,
        ST_DIV_MEAN,
        ST_DIV_FREQ,
        ST_SILENCE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic pulse;
        logic scan_step;
        logic commit;
        logic div_mean_start;
        logic div_step;
        logic div_freq_start;
        logic freq_load;
        logic silence;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic push_ok;
        logic div_done;
    } stat_t;

endpackage

// File: design/fbfd_ctrl.sv
// ----------------------------------------------------------------------------
// fbfd_ctrl
// Sequencer for one beat: pulse check, ring/window scan, two divisions when a
// period is accepted, silence check, result hand-off.
// ----------------------------------------------------------------------------
module fbfd_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  fbfd_pkg::stat_t stat,
    output fbfd_pkg::cmd_t  cmd
);

    fbfd_pkg::state_t state_reg;
    fbfd_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= fbfd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_ready;
        cmd            = '0;
        s_ready        = 1'b0;
        case (state_reg)
            fbfd_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = fbfd_pkg::ST_PULSE;
                end
            end
            fbfd_pkg::ST_PULSE: begin
                cmd.pulse  = 1'b1;
                state_next = fbfd_pkg::ST_SCAN;
            end
            fbfd_pkg::ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last) begin
                    state_next = fbfd_pkg::ST_COMMIT;
                end
            end
            fbfd_pkg::ST_COMMIT: begin
                cmd.commit = 1'b1;
                if (stat.push_ok) begin
                    cmd.div_mean_start = 1'b1;
                    state_next         = fbfd_pkg::ST_DIV_MEAN;
                end else begin
                    state_next = fbfd_pkg::ST_SILENCE;
                end
            end
            fbfd_pkg::ST_DIV_MEAN: begin
                if (stat.div_done) begin
                    cmd.div_freq_start = 1'b1;
                    state_next         = fbfd_pkg::ST_DIV_FREQ;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            fbfd_pkg::ST_DIV_FREQ: begin
                if (stat.div_done) begin
                    cmd.freq_load = 1'b1;
                    state_next    = fbfd_pkg::ST_SILENCE;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            fbfd_pkg::ST_SILENCE: begin
                cmd.silence = 1'b1;
                state_next  = fbfd_pkg::ST_DONE;
            end
            fbfd_pkg::ST_DONE: begin
                // wait for the output register to drain
                if (!out_valid_reg || m_ready) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = fbfd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fbfd_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = out_valid_reg;

endmodule

// File: design/fbfd_dp.sv
// ----------------------------------------------------------------------------
// fbfd_dp
// Datapath: config registers, pulse/period logic, period ring, sample
// window, scan accumulators, shared restoring divider, output register.
// ----------------------------------------------------------------------------
module fbfd_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [fbfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fbfd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [fbfd_pkg::SAMPLE_W-1:0]      s_light_sample,
    input  logic [fbfd_pkg::TIME_W-1:0]        s_time_ms,
    input  logic                               s_window_tick,
    output logic [fbfd_pkg::FREQ_W-1:0]        m_frequency_hz,
    output logic [fbfd_pkg::SAMPLE_W-1:0]      m_window_min,
    output logic [fbfd_pkg::SAMPLE_W-1:0]      m_window_max,
    input  fbfd_pkg::cmd_t                     cmd,
    output fbfd_pkg::stat_t                    stat
);

    // configuration
    logic [fbfd_pkg::SAMPLE_W-1:0] sens_reg;
    logic [fbfd_pkg::PERIOD_W-1:0] plow_reg;
    logic [fbfd_pkg::PERIOD_W-1:0] phigh_reg;
    logic [fbfd_pkg::PERIOD_W-1:0] sil_reg;

    // captured beat
    logic [fbfd_pkg::SAMPLE_W-1:0] sample_reg;
    logic [fbfd_pkg::TIME_W-1:0]   now_reg;
    logic                          tick_reg;

    // state
    logic [fbfd_pkg::PERIOD_W-1:0] ring_reg [fbfd_pkg::PERIOD_DEPTH];
    logic [fbfd_pkg::PIDX_W-1:0]   pslot_reg;
    logic [fbfd_pkg::TIME_W-1:0]   last_reg;
    logic [fbfd_pkg::FREQ_W-1:0]   freq_reg;
    logic [fbfd_pkg::SAMPLE_W-1:0] win_reg [fbfd_pkg::WINDOW_DEPTH];
    logic [fbfd_pkg::WIDX_W-1:0]   wslot_reg;
    logic [fbfd_pkg::SAMPLE_W-1:0] min_reg;
    logic [fbfd_pkg::SAMPLE_W-1:0] max_reg;
    logic                          push_reg;

    // scan
    logic [fbfd_pkg::SCAN_W-1:0]   scan_cnt_reg;
    logic [fbfd_pkg::SUM_W-1:0]    sum_reg;
    logic [fbfd_pkg::CNT_W-1:0]    cnt_reg;
    logic [fbfd_pkg::SAMPLE_W-1:0] lo_reg;
    logic [fbfd_pkg::SAMPLE_W-1:0] hi_reg;

    // divider
    logic [fbfd_pkg::DIV_W-1:0]    rem_reg;
    logic [fbfd_pkg::DIV_W-1:0]    quo_reg;
    logic [fbfd_pkg::DIV_W-1:0]    dvs_reg;
    logic [fbfd_pkg::DCNT_W-1:0]   dcnt_reg;

    // output
    logic [fbfd_pkg::FREQ_W-1:0]   out_freq_reg;
    logic [fbfd_pkg::SAMPLE_W-1:0] out_min_reg;
    logic [fbfd_pkg::SAMPLE_W-1:0] out_max_reg;

    logic [fbfd_pkg::SAMPLE_W:0]   thresh;
    logic                          is_pulse;
    logic [fbfd_pkg::TIME_W-1:0]   period;
    logic                          in_bounds;
    logic [fbfd_pkg::TIME_W-1:0]   silent_for;
    logic [fbfd_pkg::DIV_W:0]      rem_shift;
    logic                          div_ge;
    logic [fbfd_pkg::DIV_W:0]      rem_sub;
    logic [fbfd_pkg::PERIOD_W-1:0] ring_rd;
    logic [fbfd_pkg::SAMPLE_W-1:0] win_rd;
    logic                          ring_in;
    logic                          win_in;

    // pulse threshold at 11 bits, never wraps
    assign thresh    = {1'b0, min_reg} + {1'b0, sens_reg};
    assign is_pulse  = {1'b0, sample_reg} > thresh;
    assign period    = now_reg - last_reg;
    assign in_bounds = (period > {16'd0, plow_reg}) && (period < {16'd0, phigh_reg});
    assign silent_for = now_reg - last_reg;

    // restoring divider step
    assign rem_shift = {rem_reg, quo_reg[fbfd_pkg::DIV_W-1]};
    assign div_ge    = rem_shift >= {1'b0, dvs_reg};
    assign rem_sub   = rem_shift - {1'b0, dvs_reg};

    assign ring_in = int'(scan_cnt_reg) < fbfd_pkg::PERIOD_DEPTH;
    assign win_in  = int'(scan_cnt_reg) < fbfd_pkg::WINDOW_DEPTH;
    assign ring_rd = ring_in ? ring_reg[scan_cnt_reg[fbfd_pkg::PIDX_W-1:0]] : '0;
    assign win_rd  = win_in ? win_reg[scan_cnt_reg[fbfd_pkg::WIDX_W-1:0]] : min_reg;

    assign stat.scan_last = scan_cnt_reg == fbfd_pkg::SCAN_W'(fbfd_pkg::SCAN_N - 1);
    assign stat.push_ok   = push_reg && (cnt_reg != '0);
    assign stat.div_done  = dcnt_reg == '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sens_reg  <= fbfd_pkg::SENS_RST;
            plow_reg  <= fbfd_pkg::PLOW_RST;
            phigh_reg <= fbfd_pkg::PHIGH_RST;
            sil_reg   <= fbfd_pkg::SIL_RST;
        end else if (cfg_we) begin
            case (fbfd_pkg::cfg_idx_t'(cfg_index))
                fbfd_pkg::CFG_SENSITIVITY: sens_reg  <= cfg_data[fbfd_pkg::SAMPLE_W-1:0];
                fbfd_pkg::CFG_PERIOD_LOW:  plow_reg  <= cfg_data;
                fbfd_pkg::CFG_PERIOD_HIGH: phigh_reg <= cfg_data;
                fbfd_pkg::CFG_SILENCE:     sil_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sample_reg <= s_light_sample;
            now_reg    <= s_time_ms;
            tick_reg   <= s_window_tick;
        end
    end

    // ring, window, pulse time, frequency, min/max
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < fbfd_pkg::PERIOD_DEPTH; k++) begin
                ring_reg[k] <= '0;
            end
            for (int k = 0; k < fbfd_pkg::WINDOW_DEPTH; k++) begin
                win_reg[k] <= fbfd_pkg::WINDOW_RST;
            end
            pslot_reg <= '0;
            wslot_reg <= '0;
            last_reg  <= '0;
            freq_reg  <= '0;
            min_reg   <= fbfd_pkg::WINDOW_RST;
            max_reg   <= fbfd_pkg::WINDOW_RST;
            push_reg  <= 1'b0;
        end else begin
            if (cmd.pulse) begin
                push_reg <= is_pulse && in_bounds;
                if (is_pulse) begin
                    last_reg <= now_reg;
                    if (in_bounds) begin
                        ring_reg[pslot_reg] <= period[fbfd_pkg::PERIOD_W-1:0];
                        if (pslot_reg == fbfd_pkg::PIDX_W'(fbfd_pkg::PERIOD_DEPTH - 1)) begin
                            pslot_reg <= '0;
                        end else begin
                            pslot_reg <= pslot_reg + 1'b1;
                        end
                    end
                end
                if (tick_reg) begin
                    win_reg[wslot_reg] <= sample_reg;
                    if (wslot_reg == fbfd_pkg::WIDX_W'(fbfd_pkg::WINDOW_DEPTH - 1)) begin
                        wslot_reg <= '0;
                    end else begin
                        wslot_reg <= wslot_reg + 1'b1;
                    end
                end
            end
            if (cmd.commit && tick_reg) begin
                min_reg <= lo_reg;
                max_reg <= hi_reg;
            end
            if (cmd.freq_load) begin
                freq_reg <= (|quo_reg[fbfd_pkg::DIV_W-1:fbfd_pkg::FREQ_W]) ?
                            fbfd_pkg::FREQ_MAX : quo_reg[fbfd_pkg::FREQ_W-1:0];
            end
            if (cmd.silence && (silent_for > {16'd0, sil_reg})) begin
                freq_reg <= '0;
            end
        end
    end

    // scan accumulators
    always_ff @(posedge aclk) begin
        if (cmd.pulse) begin
            scan_cnt_reg <= '0;
            sum_reg      <= '0;
            cnt_reg      <= '0;
            lo_reg       <= fbfd_pkg::SAMPLE_MAX;
            hi_reg       <= '0;
        end else if (cmd.scan_step) begin
            scan_cnt_reg <= scan_cnt_reg + 1'b1;
            sum_reg      <= sum_reg + fbfd_pkg::SUM_W'(ring_rd);
            if (ring_rd != '0) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (win_in && (win_rd < lo_reg)) begin
                lo_reg <= win_rd;
            end
            if (win_in && (win_rd > hi_reg)) begin
                hi_reg <= win_rd;
            end
        end
    end

    // shared divider: sum / count, then 1000 / mean
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg <= '0;
        end else if (cmd.div_mean_start) begin
            rem_reg  <= '0;
            quo_reg  <= sum_reg;
            dvs_reg  <= fbfd_pkg::DIV_W'(cnt_reg);
            dcnt_reg <= fbfd_pkg::DCNT_W'(fbfd_pkg::DIV_W);
        end else if (cmd.div_freq_start) begin
            rem_reg  <= '0;
            quo_reg  <= fbfd_pkg::DIV_W'(fbfd_pkg::FREQ_NUM);
            dvs_reg  <= quo_reg;
            dcnt_reg <= fbfd_pkg::DCNT_W'(fbfd_pkg::DIV_W);
        end else if (cmd.div_step) begin
            rem_reg  <= div_ge ? rem_sub[fbfd_pkg::DIV_W-1:0] : rem_shift[fbfd_pkg::DIV_W-1:0];
            quo_reg  <= {quo_reg[fbfd_pkg::DIV_W-2:0], div_ge};
            dcnt_reg <= dcnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_freq_reg <= freq_reg;
            out_min_reg  <= min_reg;
            out_max_reg  <= max_reg;
        end
    end

    assign m_frequency_hz = out_freq_reg;
    assign m_window_min   = out_min_reg;
    assign m_window_max   = out_max_reg;

endmodule

// File: design/flash_beacon_frequency_detector.sv
// ----------------------------------------------------------------------------
// flash_beacon_frequency_detector
// Light-pulse period meter: detects pulses against a sliding-window floor,
// averages accepted periods in a ring and reports 1000 / mean in hertz.
// ----------------------------------------------------------------------------
//
//  channel  ports                                      dir  per beat
//  -------  -----------------------------------------  ---  ----------------
//  s_       s_valid/s_ready, light_sample, time_ms,    in   one sample
//           window_tick
//  m_       m_valid/m_ready, frequency_hz,             out  one result
//           window_min, window_max
//  cfg_     cfg_we, cfg_index, cfg_data                in   one register write
//
//  One beat at a time. A beat runs through accept, pulse check, the scan,
//  commit, silence check and hand-off; when a period lands in the ring the
//  shared 20-bit restoring divider runs twice (mean, then 1000 / mean)
//  between commit and silence check.
//  Reset (aresetn, synchronous) restores config defaults, clears the ring,
//  fills the window with 512; no clearing pass is needed.
//  The result sits in an output register: a stalled m_ready only holds the
//  block in its hand-off cycle once a second result is ready.
//
module flash_beacon_frequency_detector (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [fbfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fbfd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [fbfd_pkg::SAMPLE_W-1:0]      s_light_sample,
    input  logic [fbfd_pkg::TIME_W-1:0]        s_time_ms,
    input  logic                               s_window_tick,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [fbfd_pkg::FREQ_W-1:0]        m_frequency_hz,
    output logic [fbfd_pkg::SAMPLE_W-1:0]      m_window_min,
    output logic [fbfd_pkg::SAMPLE_W-1:0]      m_window_max
);

    fbfd_pkg::cmd_t  cmd;
    fbfd_pkg::stat_t stat;

    // sequencer
    fbfd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // registers, ring, window, divider
    fbfd_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_light_sample (s_light_sample),
        .s_time_ms      (s_time_ms),
        .s_window_tick  (s_window_tick),
        .m_frequency_hz (m_frequency_hz),
        .m_window_min   (m_window_min),
        .m_window_max   (m_window_max),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule

// File: tb/flash_beacon_frequency_detector_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_beacon_frequency_detector_test
// Drives light samples into the detector through its valid/ready channel,
// keeps a cycle-free model of the period ring and sample window, and checks
// every reading beat field by field against it under random idling and
// output back-pressure.
// ----------------------------------------------------------------------------
module flash_beacon_frequency_detector_test;

    localparam int IDLE_PCT     = 38;    // chance per cycle that a side idles
    localparam int TOTAL_BEATS  = 1150;  // sample beats before the run winds down
    localparam int PHASE_BEATS  = 120;   // sample beats per register setting
    localparam int HOLD_CYCLES  = 600;   // long receiver hold-off
    localparam int STALL_LIMIT  = 4000;  // cycles without any beat before giving up
    localparam int TAIL_CYCLES  = 64;    // one worst-case beat and margin

    // sensitivity reset value at register write width
    localparam logic [fbfd_pkg::CFG_DATA_W-1:0] SENS_DEFAULT =
        fbfd_pkg::CFG_DATA_W'(fbfd_pkg::SENS_RST);

    // one reading beat as the block reports it
    typedef struct packed {
        logic [fbfd_pkg::FREQ_W-1:0]   hz;
        logic [fbfd_pkg::SAMPLE_W-1:0] win_min;
        logic [fbfd_pkg::SAMPLE_W-1:0] win_max;
    } reading_t;

    logic                            aclk;
    logic                            aresetn        = 1'b0;
    logic                            cfg_we         = 1'b0;
    logic [fbfd_pkg::CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [fbfd_pkg::CFG_DATA_W-1:0] cfg_data       = '0;
    logic                            s_valid        = 1'b0;
    logic                            s_ready;
    logic [fbfd_pkg::SAMPLE_W-1:0]   s_light_sample = '0;
    logic [fbfd_pkg::TIME_W-1:0]     s_time_ms      = '0;
    logic                            s_window_tick  = 1'b0;
    logic                            m_valid;
    logic                            m_ready        = 1'b0;
    logic [fbfd_pkg::FREQ_W-1:0]     m_frequency_hz;
    logic [fbfd_pkg::SAMPLE_W-1:0]   m_window_min;
    logic [fbfd_pkg::SAMPLE_W-1:0]   m_window_max;

    flash_beacon_frequency_detector u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_light_sample (s_light_sample),
        .s_time_ms      (s_time_ms),
        .s_window_tick  (s_window_tick),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frequency_hz (m_frequency_hz),
        .m_window_min   (m_window_min),
        .m_window_max   (m_window_max)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Meter model: register mirror plus the block's state
    // ------------------------------------------------------------------
    logic [fbfd_pkg::SAMPLE_W-1:0] sens_cfg;
    logic [fbfd_pkg::PERIOD_W-1:0] plow_cfg;
    logic [fbfd_pkg::PERIOD_W-1:0] phigh_cfg;
    logic [fbfd_pkg::PERIOD_W-1:0] silence_cfg;

    logic [fbfd_pkg::PERIOD_W-1:0] period_ring [fbfd_pkg::PERIOD_DEPTH];
    int unsigned                   period_slot;
    logic [fbfd_pkg::TIME_W-1:0]   last_flash_ms;
    logic [fbfd_pkg::FREQ_W-1:0]   freq_now;
    logic [fbfd_pkg::SAMPLE_W-1:0] sample_ring [fbfd_pkg::WINDOW_DEPTH];
    int unsigned                   sample_slot;
    logic [fbfd_pkg::SAMPLE_W-1:0] floor_now;
    logic [fbfd_pkg::SAMPLE_W-1:0] peak_now;

    reading_t    readings_due[$];   // readings owed by the block, oldest first
    int unsigned beats_sent  = 0;
    int unsigned mismatches  = 0;
    int unsigned hold_cycles = 0;
    bit          steady      = 1'b0;  // no idling on either side
    logic [fbfd_pkg::TIME_W-1:0] beacon_ms = '0; // time of the last flash placed

    function automatic void restore_meter_defaults();
        sens_cfg      = fbfd_pkg::SENS_RST;
        plow_cfg      = fbfd_pkg::PLOW_RST;
        phigh_cfg     = fbfd_pkg::PHIGH_RST;
        silence_cfg   = fbfd_pkg::SIL_RST;
        foreach (period_ring[k]) period_ring[k] = '0;
        period_slot   = 0;
        last_flash_ms = '0;
        freq_now      = '0;
        foreach (sample_ring[k]) sample_ring[k] = fbfd_pkg::WINDOW_RST;
        sample_slot   = 0;
        floor_now     = fbfd_pkg::WINDOW_RST;
        peak_now      = fbfd_pkg::WINDOW_RST;
    endfunction

    // Advances the model by one sample and returns the reading it owes.
    // Order: pulse test against the old floor, silence test, window update.
    function automatic reading_t predict_reading(logic [fbfd_pkg::SAMPLE_W-1:0] smp,
                                                 logic [fbfd_pkg::TIME_W-1:0] now_ms,
                                                 logic tick);
        logic [fbfd_pkg::TIME_W-1:0]   elapsed;
        int unsigned                   total;
        int unsigned                   filled;
        int unsigned                   hz_raw;
        logic [fbfd_pkg::SAMPLE_W-1:0] lo;
        logic [fbfd_pkg::SAMPLE_W-1:0] hi;
        // threshold sum is 11 bits wide, so it never wraps
        if (int'(smp) > int'(floor_now) + int'(sens_cfg)) begin
            elapsed       = now_ms - last_flash_ms;
            last_flash_ms = now_ms;
            // strict bounds; inverted or empty bounds take nothing
            if (elapsed > fbfd_pkg::TIME_W'(plow_cfg) &&
                elapsed < fbfd_pkg::TIME_W'(phigh_cfg)) begin
                period_ring[period_slot] = elapsed[fbfd_pkg::PERIOD_W-1:0];
                period_slot = (period_slot + 1) % fbfd_pkg::PERIOD_DEPTH;
                total  = 0;
                filled = 0;
                foreach (period_ring[k]) begin
                    if (period_ring[k] != 0) begin
                        total += int'(period_ring[k]);
                        filled++;
                    end
                end
                if (filled != 0 && total / filled != 0) begin
                    hz_raw   = fbfd_pkg::FREQ_NUM / (total / filled);
                    freq_now = (hz_raw > int'(fbfd_pkg::FREQ_MAX)) ?
                               fbfd_pkg::FREQ_MAX : hz_raw[fbfd_pkg::FREQ_W-1:0];
                end
            end
        end
        elapsed = now_ms - last_flash_ms;
        if (elapsed > fbfd_pkg::TIME_W'(silence_cfg)) freq_now = '0;
        if (tick) begin
            sample_ring[sample_slot] = smp;
            sample_slot = (sample_slot + 1) % fbfd_pkg::WINDOW_DEPTH;
            lo = fbfd_pkg::SAMPLE_MAX;
            hi = '0;
            foreach (sample_ring[k]) begin
                if (sample_ring[k] > hi) hi = sample_ring[k];
                if (sample_ring[k] < lo) lo = sample_ring[k];
            end
            floor_now = lo;
            peak_now  = hi;
        end
        return '{hz: freq_now, win_min: floor_now, win_max: peak_now};
    endfunction

    // ------------------------------------------------------------------
    // Stimulus shaping
    // ------------------------------------------------------------------
    // background light: at or below the pulse threshold
    function automatic logic [fbfd_pkg::SAMPLE_W-1:0] quiet_level();
        int unsigned top;
        int unsigned bottom;
        top = int'(floor_now) + int'(sens_cfg);
        if (top > 1023) top = 1023;
        bottom = (top > 60) ? top - 60 : 0;
        return fbfd_pkg::SAMPLE_W'($urandom_range(top, bottom));
    endfunction

    // flash: above the threshold where one is possible
    function automatic logic [fbfd_pkg::SAMPLE_W-1:0] flash_level();
        int unsigned thr;
        thr = int'(floor_now) + int'(sens_cfg);
        if (thr >= 1023) return fbfd_pkg::SAMPLE_MAX;
        return fbfd_pkg::SAMPLE_W'($urandom_range(1023, thr + 1));
    endfunction

    // mostly inside the bounds, with the bounds themselves and strays
    function automatic int unsigned pick_period();
        int unsigned lo_p;
        int unsigned hi_p;
        if (int'(phigh_cfg) <= int'(plow_cfg) + 1) return $urandom_range(1500, 1);
        lo_p = int'(plow_cfg) + 1;
        hi_p = int'(phigh_cfg) - 1;
        if (hi_p > lo_p + 1500) hi_p = lo_p + 1500;
        case ($urandom_range(9))
            0:       return int'(plow_cfg);
            1:       return int'(phigh_cfg);
            2:       return lo_p;
            3:       return hi_p;
            4:       return $urandom_range(3000, 1);
            default: return $urandom_range(hi_p, lo_p);
        endcase
    endfunction

    task automatic report_fault(string msg);
        if (mismatches < 10) $display("%0t: %s", $time, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------
    // One sample beat. Returns right after the accepting edge, with valid
    // still high so a back-to-back beat keeps it up.
    task automatic send_sample(logic [fbfd_pkg::SAMPLE_W-1:0] smp,
                               logic [fbfd_pkg::TIME_W-1:0] now_ms,
                               logic tick);
        @(negedge aclk);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_light_sample <= smp;
        s_time_ms      <= now_ms;
        s_window_tick  <= tick;
        do @(posedge aclk); while (!s_ready);
        readings_due.push_back(predict_reading(smp, now_ms, tick));
        beats_sent++;
    endtask

    // sender goes quiet until every owed reading is in
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (readings_due.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(fbfd_pkg::cfg_idx_t idx,
                             logic [fbfd_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            fbfd_pkg::CFG_SENSITIVITY: sens_cfg    = val[fbfd_pkg::SAMPLE_W-1:0];
            fbfd_pkg::CFG_PERIOD_LOW:  plow_cfg    = val;
            fbfd_pkg::CFG_PERIOD_HIGH: phigh_cfg   = val;
            fbfd_pkg::CFG_SILENCE:     silence_cfg = val;
            default: ;
        endcase
    endtask

    // registers change only with the block empty
    task automatic set_config(logic [fbfd_pkg::CFG_DATA_W-1:0] sens,
                              logic [fbfd_pkg::CFG_DATA_W-1:0] plow,
                              logic [fbfd_pkg::CFG_DATA_W-1:0] phigh,
                              logic [fbfd_pkg::CFG_DATA_W-1:0] sil);
        wait_drained();
        write_reg(fbfd_pkg::CFG_SENSITIVITY, sens);
        write_reg(fbfd_pkg::CFG_PERIOD_LOW, plow);
        write_reg(fbfd_pkg::CFG_PERIOD_HIGH, phigh);
        write_reg(fbfd_pkg::CFG_SILENCE, sil);
    endtask

    // background samples spread over one period, then the flash
    task automatic send_flash_cycle();
        int unsigned gap_ms;
        int unsigned quiet_n;
        gap_ms  = pick_period();
        quiet_n = (gap_ms > 3) ? $urandom_range(3) : 0;
        for (int k = 1; k <= quiet_n; k++)
            send_sample(quiet_level(), beacon_ms + k * gap_ms / (quiet_n + 1),
                        $urandom_range(99) < 30);
        beacon_ms += gap_ms;
        send_sample(flash_level(), beacon_ms, $urandom_range(99) < 15);
    endtask

    // any sample, any time: jumps, repeats and stray levels
    task automatic send_noise();
        case ($urandom_range(2))
            0:       beacon_ms = $urandom();
            1:       beacon_ms += $urandom_range(5000);
            default: ;
        endcase
        send_sample(fbfd_pkg::SAMPLE_W'($urandom_range(1023)), beacon_ms,
                    1'($urandom_range(1)));
    endtask

    // ------------------------------------------------------------------
    // Receiver: random ready, or a counted hold-off when one is armed
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Reading checker: each beat against the oldest owed reading
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_readings
        reading_t want;
        if (m_valid === 1'b1 && m_ready) begin
            if (readings_due.size() == 0) begin
                report_fault($sformatf("reading with none owed: hz=%0d min=%0d max=%0d",
                                       m_frequency_hz, m_window_min, m_window_max));
            end else begin
                want = readings_due.pop_front();
                if (m_frequency_hz !== want.hz)
                    report_fault($sformatf("frequency_hz: expected %0d, got %0d",
                                           want.hz, m_frequency_hz));
                if (m_window_min !== want.win_min)
                    report_fault($sformatf("window_min: expected %0d, got %0d",
                                           want.win_min, m_window_min));
                if (m_window_max !== want.win_max)
                    report_fault($sformatf("window_max: expected %0d, got %0d",
                                           want.win_max, m_window_max));
            end
        end
    end

    // watchdog: too long with no beat on either channel
    initial begin : watchdog
        int unsigned quiet_edges;
        quiet_edges = 0;
        while (quiet_edges < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready))
                quiet_edges = 0;
            else
                quiet_edges++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------
    // Empty ring, wide-open bounds: short periods push 1000 / mean past 31.
    task automatic test_frequency_saturation();
        set_config(SENS_DEFAULT, 16'd0, 16'hFFFF, 16'hFFFF);
        send_sample(10'd600, 32'd5, 1'b0);       // period 5: saturates
        send_sample(10'd600, 32'd6, 1'b0);       // period 1
        send_sample(10'd600, 32'd65540, 1'b0);   // 65534, just under the top bound
        send_sample(10'd600, 32'd131075, 1'b0);  // 65535 equals the bound: rejected
    endtask

    task automatic test_default_flashes();
        set_config(SENS_DEFAULT, fbfd_pkg::PLOW_RST, fbfd_pkg::PHIGH_RST,
                   fbfd_pkg::SIL_RST);
        send_sample(10'd700, 32'd200000, 1'b0);
        send_sample(10'd0, 32'd200050, 1'b0);
        send_sample(10'd1023, 32'd200100, 1'b0);
        send_sample(10'd0, 32'd200800, 1'b0);    // 700 ms dark: frequency drops
    endtask

    // threshold at its top (floor 512 + 1023 must not wrap) and at zero
    task automatic test_threshold_extremes();
        set_config(16'hFFFF, fbfd_pkg::PLOW_RST, fbfd_pkg::PHIGH_RST, 16'd0);
        send_sample(10'd1023, 32'd200801, 1'b0);
        wait_drained();
        write_reg(fbfd_pkg::CFG_SENSITIVITY, 16'd0);
        send_sample(10'd512, 32'd200802, 1'b0);  // equal to floor: no pulse
        send_sample(10'd513, 32'd200803, 1'b0);
        send_sample(10'd0, 32'd200805, 1'b0);    // zero timeout: any gap is silence
    endtask

    task automatic test_window_extremes();
        set_config(SENS_DEFAULT, fbfd_pkg::PLOW_RST, fbfd_pkg::PHIGH_RST,
                   fbfd_pkg::SIL_RST);
        send_sample(10'd0, 32'd200900, 1'b1);
        send_sample(10'd1023, 32'd200901, 1'b1); // pulse judged on the old floor
    endtask

    task automatic test_period_bounds();
        send_sample(10'd100, 32'd200941, 1'b0);  // 40: on the low bound
        send_sample(10'd100, 32'd200982, 1'b0);  // 41
        send_sample(10'd100, 32'd201581, 1'b0);  // 599
        send_sample(10'd100, 32'd202181, 1'b0);  // 600: on the high bound
        set_config(SENS_DEFAULT, 16'd500, 16'd100, fbfd_pkg::SIL_RST);
        send_sample(10'd100, 32'd202381, 1'b0);  // inverted bounds take nothing
    endtask

    task automatic test_time_wrap();
        set_config(SENS_DEFAULT, fbfd_pkg::PLOW_RST, fbfd_pkg::PHIGH_RST,
                   fbfd_pkg::SIL_RST);
        send_sample(10'd900, 32'hFFFF_FFC0, 1'b0);
        send_sample(10'd900, 32'h0000_0020, 1'b1); // 96 ms across the wrap
    endtask

    // ------------------------------------------------------------------
    // Pressure tests
    // ------------------------------------------------------------------
    // receiver holds off while the sender keeps offering: input must stall
    task automatic test_output_backpressure();
        set_config(SENS_DEFAULT, fbfd_pkg::PLOW_RST, fbfd_pkg::PHIGH_RST,
                   fbfd_pkg::SIL_RST);
        beacon_ms   = $urandom();
        hold_cycles = HOLD_CYCLES;
        steady      = 1'b1;
        repeat (6) send_flash_cycle();
        steady      = 1'b0;
        wait_drained();
    endtask

    task automatic test_drain_pause();
        repeat (3) begin
            repeat (2) send_flash_cycle();
            wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Random beacons over a rotation of register settings
    // ------------------------------------------------------------------
    task automatic test_random_beacons();
        int unsigned phase;
        int unsigned stop_at;
        int unsigned plow;
        phase = 0;
        while (beats_sent < TOTAL_BEATS) begin
            plow = $urandom_range(200);
            case (phase % 7)
                0: set_config(SENS_DEFAULT, fbfd_pkg::PLOW_RST, fbfd_pkg::PHIGH_RST,
                              fbfd_pkg::SIL_RST);
                1: set_config(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
                2: set_config(16'h03FF, 16'hFFFF, 16'hFFFF, 16'd0);
                4: set_config(fbfd_pkg::CFG_DATA_W'($urandom_range(100)), 16'd0,
                              fbfd_pkg::CFG_DATA_W'($urandom_range(60, 2)),
                              fbfd_pkg::CFG_DATA_W'($urandom_range(400, 30)));
                5: set_config(fbfd_pkg::CFG_DATA_W'($urandom()),
                              fbfd_pkg::CFG_DATA_W'($urandom()),
                              fbfd_pkg::CFG_DATA_W'($urandom()),
                              fbfd_pkg::CFG_DATA_W'($urandom()));
                default: set_config(fbfd_pkg::CFG_DATA_W'($urandom_range(120)),
                                    fbfd_pkg::CFG_DATA_W'(plow),
                                    fbfd_pkg::CFG_DATA_W'(plow + $urandom_range(800, 1)),
                                    fbfd_pkg::CFG_DATA_W'($urandom_range(2000, 50)));
            endcase
            steady  = (phase == 3);
            stop_at = beats_sent + PHASE_BEATS;
            while (beats_sent < stop_at && beats_sent < TOTAL_BEATS) begin
                if ($urandom_range(99) < 15) send_noise();
                else send_flash_cycle();
            end
            phase++;
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        restore_meter_defaults();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_frequency_saturation();
        test_default_flashes();
        test_threshold_extremes();
        test_window_extremes();
        test_period_bounds();
        test_time_wrap();
        test_output_backpressure();
        test_drain_pause();
        test_random_beacons();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (readings_due.size() != 0)
            report_fault($sformatf("%0d readings never arrived", readings_due.size()));
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
